// ===== rtl/ame_pkg.sv =====
// Adjacency matrix engine: shared types and constants.
// Request modes, decoded operations, command and result beats.
// No dependencies.
`timescale 1ns / 1ps

package ame_pkg;

  // Field widths fixed by the interface
  localparam int unsigned ModeW = 3;
  localparam int unsigned IdxW  = 5;
  localparam int unsigned VcW   = 6;
  localparam int unsigned LimW  = 6;

  // vertex_count after reset
  localparam logic [VcW-1:0] VcReset = 6'd32;
  // a listing never scans past this many vertices
  localparam logic [LimW-1:0] ScanCap = 6'd32;

  // Request modes as they arrive on the mode port
  localparam logic [ModeW-1:0] MODE_ADD      = 3'd0;
  localparam logic [ModeW-1:0] MODE_REMOVE   = 3'd1;
  localparam logic [ModeW-1:0] MODE_TEST     = 3'd2;
  localparam logic [ModeW-1:0] MODE_LIST_OUT = 3'd3;
  localparam logic [ModeW-1:0] MODE_LIST_IN  = 3'd4;

  // Operation after range check; bad indices and unknown modes fold into OP_ERROR
  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_REMOVE   = 3'd1,
    OP_TEST     = 3'd2,
    OP_LIST_OUT = 3'd3,
    OP_LIST_IN  = 3'd4,
    OP_ERROR    = 3'd5
  } op_e;

  // Command beat from front end to back end
  typedef struct packed {
    op_e             op;
    logic [IdxW-1:0] src;
    logic [IdxW-1:0] dst;
    logic [LimW-1:0] lim;   // vertices to scan for a listing
  } cmd_t;

  // Result beat
  typedef struct packed {
    logic            edge_present;
    logic [IdxW-1:0] neighbour;
    logic            none_found;
    logic            error;
    logic            last;
  } res_t;

endpackage

// ===== rtl/ame_fifo.sv =====
// Adjacency matrix engine: small synchronous queue.
// Used for the command queue and the result queue. Uses no package.
`timescale 1ns / 1ps

module ame_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/ame_front.sv =====
// Adjacency matrix engine: front end.
// Decodes the mode, range-checks the indices and queues commands.
// Depends on ame_pkg and ame_fifo.
`timescale 1ns / 1ps

module ame_front #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic [ame_pkg::ModeW-1:0] mode_i,
  input  logic [ame_pkg::IdxW-1:0]  source_vertex_i,
  input  logic [ame_pkg::IdxW-1:0]  dest_vertex_i,
  input  logic [ame_pkg::VcW-1:0]   vertex_count_i,
  output ame_pkg::cmd_t             cmd_o,
  output logic                      cmd_empty_o,
  input  logic                      cmd_pop_i
);

  localparam logic [6:0] MaxV = 7'(MAX_VERTICES);

  logic [6:0]             cnt;
  logic                   src_ok, dst_ok;
  ame_pkg::cmd_t          cmd;

  // effective vertex count: min(vertex_count, MAX_VERTICES)
  always_comb begin
    cnt = (7'(vertex_count_i) > MaxV) ? MaxV : 7'(vertex_count_i);
  end

  assign src_ok = (7'(source_vertex_i) < cnt);
  assign dst_ok = (7'(dest_vertex_i) < cnt);

  // classify the request
  always_comb begin
    cmd.src = source_vertex_i;
    cmd.dst = dest_vertex_i;
    cmd.lim = (cnt > 7'(ame_pkg::ScanCap)) ? ame_pkg::ScanCap : 6'(cnt);
    unique case (mode_i)
      ame_pkg::MODE_ADD:
        cmd.op = (src_ok && dst_ok) ? ame_pkg::OP_ADD : ame_pkg::OP_ERROR;
      ame_pkg::MODE_REMOVE:
        cmd.op = (src_ok && dst_ok) ? ame_pkg::OP_REMOVE : ame_pkg::OP_ERROR;
      ame_pkg::MODE_TEST:
        cmd.op = (src_ok && dst_ok) ? ame_pkg::OP_TEST : ame_pkg::OP_ERROR;
      ame_pkg::MODE_LIST_OUT:
        cmd.op = src_ok ? ame_pkg::OP_LIST_OUT : ame_pkg::OP_ERROR;
      ame_pkg::MODE_LIST_IN:
        cmd.op = dst_ok ? ame_pkg::OP_LIST_IN : ame_pkg::OP_ERROR;
      default:
        cmd.op = ame_pkg::OP_ERROR;
    endcase
  end

  // command queue towards the back end
  ame_fifo #(
    .WIDTH($bits(ame_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cmd),
    .full_o (full_o),
    .pop_i  (cmd_pop_i),
    .data_o (cmd_o),
    .empty_o(cmd_empty_o)
  );

endmodule

// ===== rtl/ame_back.sv =====
// Adjacency matrix engine: back end.
// Holds the edge matrix memory, runs the edge and scan sequencer and queues results.
// Depends on ame_pkg and ame_fifo.
`timescale 1ns / 1ps

module ame_back #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ame_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output ame_pkg::res_t res_o,
  output logic          res_empty_o,
  input  logic          res_pop_i
);

  // only vertices below 32 are reachable through 5-bit indices
  localparam int unsigned N  = (MAX_VERTICES < 32) ? MAX_VERTICES : 32;
  localparam int unsigned IW = $clog2(N);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_FETCH = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  ame_pkg::cmd_t  cmd_q, cmd_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic [IW-1:0]  pend_q, pend_d;
  logic           pend_vld_q, pend_vld_d;

  // matrix memory, one row per source vertex, with a valid bit per row
  logic [N-1:0]   mem_q [N];
  logic [N-1:0]   row_vld_q;
  logic [N-1:0]   rdata_q;
  logic           rvld_q;
  logic           rd_en, wr_en;
  logic [IW-1:0]  rd_addr;
  logic [N-1:0]   wr_data;

  logic [IW-1:0]  src_t, dst_t;
  logic [N-1:0]   row_data, dst_mask;
  logic           hit, scan_end;

  logic           res_push, res_full;
  ame_pkg::res_t  res;

  assign src_t    = cmd_q.src[IW-1:0];
  assign dst_t    = cmd_q.dst[IW-1:0];
  assign row_data = rvld_q ? rdata_q : '0;
  assign dst_mask = {{(N-1){1'b0}}, 1'b1} << dst_t;

  // current scan bit: row bit for out-neighbours, column bit for in-neighbours
  assign hit      = (cmd_q.op == ame_pkg::OP_LIST_OUT) ? row_data[idx_q] : row_data[dst_t];
  assign scan_end = ((ame_pkg::LimW'(idx_q) + ame_pkg::LimW'(1)) == cmd_q.lim);

  // sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    cmd_pop_o  = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = src_t;
    wr_en      = 1'b0;
    wr_data    = row_data | dst_mask;
    res_push   = 1'b0;
    res        = '0;
    res.last   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o  = 1'b1;
          cmd_d      = cmd_i;
          idx_d      = '0;
          pend_vld_d = 1'b0;
          state_d    = ST_FETCH;
        end
      end

      ST_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = (cmd_q.op == ame_pkg::OP_LIST_IN) ? idx_q : src_t;
        if (cmd_q.op == ame_pkg::OP_LIST_OUT || cmd_q.op == ame_pkg::OP_LIST_IN) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_EXEC;
        end
      end

      // single-beat operations
      ST_EXEC: begin
        unique case (cmd_q.op)
          ame_pkg::OP_ADD: begin
            wr_data = row_data | dst_mask;
          end
          ame_pkg::OP_REMOVE: begin
            wr_data = row_data & ~dst_mask;
          end
          ame_pkg::OP_TEST: begin
            res.edge_present = row_data[dst_t];
          end
          default: begin
            res.error = 1'b1;
          end
        endcase
        if (!res_full) begin
          res_push = 1'b1;
          wr_en    = (cmd_q.op == ame_pkg::OP_ADD) || (cmd_q.op == ame_pkg::OP_REMOVE);
          state_d  = ST_IDLE;
        end
      end

      // one vertex per cycle unless a pending hit meets a full result queue; a hit
      // is held back until a later hit or the scan end shows whether it is the last
      ST_SCAN: begin
        res.neighbour = ame_pkg::IdxW'(pend_q);
        res.last      = 1'b0;
        if (!(hit && pend_vld_q && res_full)) begin
          res_push = hit && pend_vld_q;
          if (hit) begin
            pend_d     = idx_q;
            pend_vld_d = 1'b1;
          end
          if (scan_end) begin
            state_d = ST_DONE;
          end else begin
            idx_d = idx_q + IW'(1);
            if (cmd_q.op == ame_pkg::OP_LIST_IN) begin
              rd_en   = 1'b1;
              rd_addr = idx_q + IW'(1);
            end
          end
        end
      end

      // closing beat of a listing
      ST_DONE: begin
        if (pend_vld_q) begin
          res.neighbour = ame_pkg::IdxW'(pend_q);
        end else begin
          res.none_found = 1'b1;
        end
        if (!res_full) begin
          res_push = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_vld_q <= 1'b0;
      row_vld_q  <= '0;
      rvld_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      if (wr_en) begin
        row_vld_q[src_t] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= row_vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    pend_q <= pend_d;
  end

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[src_t] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // result queue
  ame_fifo #(
    .WIDTH($bits(ame_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res),
    .full_o (res_full),
    .pop_i  (res_pop_i),
    .data_o (res_o),
    .empty_o(res_empty_o)
  );

endmodule

// ===== rtl/adjacency_matrix_engine.sv =====
// Adjacency matrix engine: top level.
// Holds the vertex_count register and joins the front end and back end.
// Depends on ame_pkg, ame_front and ame_back.
//
// Keeps a directed graph as a bit matrix and serves add, remove, test and
// neighbour-listing requests through a queue-style port on each side. The
// matrix is empty straight after reset (per-row valid bits, no clearing pass),
// so requests are taken from the first cycle. Once out of the two-entry command
// queue, an add, remove, test or error request is fetched and executed; a
// listing is fetched, scanned over lim = min(vertex count, MAX_VERTICES, 32)
// vertices and closed. The single matrix read port delivers one row a cycle and
// the scan checks one vertex a cycle. A full result queue stalls the back end,
// the command queue then absorbs up to two more requests. vertex_count may only
// be written while no request is in flight.
`timescale 1ns / 1ps

module adjacency_matrix_engine #(
  parameter int unsigned MAX_VERTICES = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request side
  input  logic                      push,
  output logic                      full,
  input  logic [ame_pkg::ModeW-1:0] mode_i,
  input  logic [ame_pkg::IdxW-1:0]  source_vertex_i,
  input  logic [ame_pkg::IdxW-1:0]  dest_vertex_i,
  // result side
  output logic                      empty,
  input  logic                      pop,
  output logic                      edge_present_o,
  output logic [ame_pkg::IdxW-1:0]  neighbour_o,
  output logic                      none_found_o,
  output logic                      error_o,
  output logic                      last_o,
  // configuration
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [ame_pkg::VcW-1:0]   cfg_data_i
);

  logic [ame_pkg::VcW-1:0] vertex_count_q;
  ame_pkg::cmd_t           cmd;
  logic                    cmd_empty, cmd_pop;
  ame_pkg::res_t           res;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= ame_pkg::VcReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vertex_count_q <= cfg_data_i;
    end
  end

  ame_front #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .mode_i         (mode_i),
    .source_vertex_i(source_vertex_i),
    .dest_vertex_i  (dest_vertex_i),
    .vertex_count_i (vertex_count_q),
    .cmd_o          (cmd),
    .cmd_empty_o    (cmd_empty),
    .cmd_pop_i      (cmd_pop)
  );

  ame_back #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res),
    .res_empty_o(empty),
    .res_pop_i  (pop)
  );

  assign edge_present_o = res.edge_present;
  assign neighbour_o    = res.neighbour;
  assign none_found_o   = res.none_found;
  assign error_o        = res.error;
  assign last_o         = res.last;

endmodule

// ===== rtl/ame_checker.sv =====
// Adjacency matrix engine: port-level checker and its bind to the top level.
// Depends on ame_pkg for field widths.
`timescale 1ns / 1ps

module ame_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     empty_i,
  input logic                     pop_i,
  input logic                     edge_present_i,
  input logic [ame_pkg::IdxW-1:0] neighbour_i,
  input logic                     none_found_i,
  input logic                     error_i,
  input logic                     last_i
);

  // a waiting result beat holds until it is taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && !pop_i) |=> (!empty_i && $stable(neighbour_i) && $stable(last_i)
      && $stable(error_i) && $stable(none_found_i) && $stable(edge_present_i)))
    else $error("result beat changed while stalled");

  // an error ends its request and carries nothing else
  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && error_i) |-> (last_i && !edge_present_i && !none_found_i
      && neighbour_i == '0))
    else $error("malformed error beat");

  // an empty listing is a single closing beat
  a_none_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && none_found_i) |-> (last_i && !error_i && !edge_present_i
      && neighbour_i == '0))
    else $error("malformed none-found beat");

  // a test hit is a single closing beat
  a_test_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_i && edge_present_i) |-> (last_i && neighbour_i == '0))
    else $error("malformed edge-present beat");

endmodule

bind adjacency_matrix_engine ame_checker u_ame_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty_i       (empty),
  .pop_i         (pop),
  .edge_present_i(edge_present_o),
  .neighbour_i   (neighbour_o),
  .none_found_i  (none_found_o),
  .error_i       (error_o),
  .last_i        (last_o)
);
